@@ design/sfa_pkg.sv @@
// Shared types, constants and size-class functions for the segregated fit allocator.
// Used by the front end, the back end and the top level.
package sfa_pkg;

  localparam int unsigned NUM_CLASSES = 54;
  localparam int unsigned CLS_W       = 6;
  localparam int unsigned MAX_SIZE    = 3840;
  localparam int unsigned MIN_SIZE    = 24;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_OVERSIZE  = 3'd2,
    ST_NO_MEM    = 3'd3,
    ST_BAD_ADDR  = 3'd4,
    ST_NOT_ALLOC = 3'd5
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [15:0] request_size;
    logic [15:0] free_address;
  } req_t;

  typedef struct packed {
    logic [15:0] address;
    logic [2:0]  status;
  } rsp_t;

  // classified word passed from front to back
  typedef struct packed {
    logic             op;
    logic             reject;
    status_e          status;
    logic [11:0]      size;
    logic [CLS_W-1:0] cls;
    logic [15:0]      start;
  } job_t;

  function automatic logic [11:0] class_size(input logic [11:0] s);
    logic [11:0] m;
    begin
      if (s <= 12'd24) return 12'd24;
      if (s <= 12'd128) m = 12'd7;
      else if (s <= 12'd256) m = 12'd15;
      else if (s <= 12'd512) m = 12'd31;
      else if (s <= 12'd1024) m = 12'd63;
      else if (s <= 12'd2048) m = 12'd127;
      else m = 12'd255;
      return (s + m) & ~m;
    end
  endfunction

  function automatic logic [CLS_W-1:0] class_index(input logic [12:0] sz);
    logic [12:0] s;
    logic [12:0] i;
    begin
      s = (sz < 13'd16) ? 13'd16 : sz;
      if (s <= 13'd128) i = (s >> 3) - 13'd2;
      else if (s <= 13'd256) i = 13'd14 + ((s - 13'd128) >> 4);
      else if (s <= 13'd512) i = 13'd22 + ((s - 13'd256) >> 5);
      else if (s <= 13'd1024) i = 13'd30 + ((s - 13'd512) >> 6);
      else if (s <= 13'd2048) i = 13'd38 + ((s - 13'd1024) >> 7);
      else if (s <= 13'd3840) i = 13'd46 + ((s - 13'd2048) >> 8);
      else i = 13'(NUM_CLASSES - 1);
      if (i >= 13'(NUM_CLASSES)) i = 13'(NUM_CLASSES - 1);
      return i[CLS_W-1:0];
    end
  endfunction

endpackage

@@ design/sfa_front.sv @@
// Front end: accepts request words and classifies them into jobs.
// Depends on sfa_pkg.
module sfa_front #(
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sfa_pkg::req_t in_data_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output sfa_pkg::job_t job_o
);

  localparam int unsigned DEPTH = 2;

  sfa_pkg::job_t    fifo_q [DEPTH];
  logic             wp_q, wp_d, rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;
  sfa_pkg::job_t    job;
  logic [11:0]      sz;
  logic [15:0]      st;
  logic             push, pop;

  always_comb begin
    job        = '0;
    job.op     = in_data_i.op;
    job.status = sfa_pkg::ST_OK;
    sz         = sfa_pkg::class_size(in_data_i.request_size[11:0]);
    st         = in_data_i.free_address - 16'(HEADER_BYTES);
    job.size   = sz;
    job.cls    = sfa_pkg::class_index({1'b0, sz});
    job.start  = st;
    if (in_data_i.op == sfa_pkg::OP_ALLOC) begin
      if (in_data_i.request_size == 16'd0) begin
        job.reject = 1'b1;
        job.status = sfa_pkg::ST_ZERO;
      end else if (in_data_i.request_size > 16'(sfa_pkg::MAX_SIZE)) begin
        job.reject = 1'b1;
        job.status = sfa_pkg::ST_OVERSIZE;
      end
    end else if (in_data_i.free_address < 16'(HEADER_BYTES) || st[2:0] != 3'd0) begin
      job.reject = 1'b1;
      job.status = sfa_pkg::ST_BAD_ADDR;
    end
  end

  assign in_ready_o  = (cnt_q != 2'(DEPTH));
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = fifo_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_valid_o && job_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= job;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(DEPTH)) else $error("queue overfilled");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'(DEPTH) |-> !in_ready_o) else $error("ready while full");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");

endmodule

@@ design/sfa_back.sv @@
// Back end: executes jobs against the class-head, header and link memories.
// Depends on sfa_pkg. Clears the header and class-head memories after reset.
module sfa_back #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [16:0]   limit_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  sfa_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sfa_pkg::rsp_t out_data_o
);

  localparam int unsigned GRAN   = HEAP_BYTES / 8;
  localparam int unsigned GW     = $clog2(GRAN);
  localparam int unsigned AW     = GW + 3;
  localparam int unsigned NC     = sfa_pkg::NUM_CLASSES;
  localparam int unsigned CW     = sfa_pkg::CLS_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_EXEC  = 6'b001000,
    S_LINK  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [GW:0]      head_mem [NC];
  logic [12:0]      hdr_mem [GRAN];
  logic [GW:0]      link_mem [GRAN];
  logic [12:0]      hdr_rd_q;
  logic [GW:0]      link_rd_q;
  logic [GW:0]      head_rd_q;
  logic [GW:0]      clr_q;
  logic [AW:0]      top_q;
  sfa_pkg::job_t    job_q;
  logic [GW-1:0]    g_q;
  logic [CW-1:0]    fcls_q;
  sfa_pkg::rsp_t    res_q;
  sfa_pkg::rsp_t    rsp_q;
  sfa_pkg::rsp_t    exec_rsp;
  logic             ov_q;
  logic             hdr_we;
  logic [GW-1:0]    hdr_wa;
  logic [12:0]      hdr_wd;
  logic             link_we;
  logic             head_we;
  logic [CW-1:0]    head_wa;
  logic [GW:0]      head_wd;
  logic [CW-1:0]    head_ra;
  logic [CW-1:0]    fcls;
  logic [GW-1:0]    rd_a;
  logic [GW:0]      head;
  logic [AW:0]      need, lim;

  assign head        = head_rd_q;
  assign fcls        = sfa_pkg::class_index(hdr_rd_q & 13'h1FFE);
  assign need        = (AW+1)'((HEADER_BYTES + {20'd0, job_q.size} + 7) & ~32'd7);
  assign lim         = ({15'd0, limit_i} > HEAP_BYTES) ? (AW+1)'(HEAP_BYTES)
                                                       : (AW+1)'(limit_i);
  assign job_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = rsp_q;

  always_comb begin
    rd_a = (job_q.op == sfa_pkg::OP_FREE) ? job_q.start[3 +: GW]
         : ((head[GW-1:0] == '0 && head != '0) ? GW'(GRAN - 1) : head[GW-1:0] - GW'(1));
    if (head > (GW+1)'(GRAN)) rd_a = GW'(GRAN - 1);
  end

  always_comb begin
    state_d = state_q;
    hdr_we  = 1'b0;
    hdr_wa  = g_q;
    hdr_wd  = 13'd0;
    link_we = 1'b0;
    head_we = 1'b0;
    head_wa = job_q.cls;
    head_wd = link_rd_q;
    head_ra = job_i.cls;
    unique case (state_q)
      S_CLEAR: begin
        hdr_we = 1'b1;
        hdr_wa = clr_q[GW-1:0];
        if (clr_q < (GW+1)'(NC)) begin
          head_we = 1'b1;
          head_wa = clr_q[CW-1:0];
          head_wd = '0;
        end
        if (clr_q == (GW+1)'(GRAN - 1)) state_d = S_IDLE;
      end
      S_IDLE:  if (job_valid_i) state_d = S_RD;
      S_RD:    state_d = job_q.reject ? S_OUT : S_EXEC;
      S_EXEC: begin
        state_d = S_OUT;
        head_ra = fcls;
        if (job_q.op == sfa_pkg::OP_FREE) begin
          if ({1'b0, job_q.start} < top_q[AW:0] && hdr_rd_q[0]) begin
            hdr_we  = 1'b1;
            hdr_wd  = hdr_rd_q & 13'h1FFE;
            state_d = S_LINK;
          end
        end else if (head != '0) begin
          hdr_we  = 1'b1;
          hdr_wd  = hdr_rd_q | 13'd1;
          head_we = 1'b1;
        end else if (top_q + need <= lim) begin
          hdr_we = 1'b1;
          hdr_wa = top_q[3 +: GW];
          hdr_wd = {1'b0, job_q.size} | 13'd1;
        end
      end
      S_LINK: begin
        link_we = 1'b1;
        head_we = 1'b1;
        head_wa = fcls_q;
        head_wd = (GW+1)'(g_q) + (GW+1)'(1);
        state_d = S_OUT;
      end
      S_OUT: if (!ov_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    exec_rsp = '0;
    if (job_q.op == sfa_pkg::OP_FREE) begin
      if ({1'b0, job_q.start} >= top_q) exec_rsp.status = sfa_pkg::ST_BAD_ADDR;
      else if (!hdr_rd_q[0]) exec_rsp.status = sfa_pkg::ST_NOT_ALLOC;
    end else if (head != '0) begin
      exec_rsp.address = 16'({g_q, 3'b000} + (AW)'(HEADER_BYTES));
    end else if (top_q + need <= lim) begin
      exec_rsp.address = 16'(top_q + (AW+1)'(HEADER_BYTES));
    end else begin
      exec_rsp.status = sfa_pkg::ST_NO_MEM;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    if (link_we) link_mem[g_q] <= head_rd_q;
    if (head_we) head_mem[head_wa] <= head_wd;
    hdr_rd_q  <= hdr_mem[rd_a];
    link_rd_q <= link_mem[rd_a];
    if (state_q == S_IDLE || state_q == S_EXEC) head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      top_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + (GW+1)'(1);
      if (state_q == S_OUT && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (state_q == S_EXEC && job_q.op == sfa_pkg::OP_ALLOC && head == '0 &&
          top_q + need <= lim) top_q <= top_q + need;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && job_valid_i) job_q <= job_i;
    if (state_q == S_RD) g_q <= rd_a;
    if (state_q == S_EXEC) fcls_q <= fcls;
    if (state_q == S_RD && job_q.reject) res_q <= {16'd0, job_q.status};
    if (state_q == S_EXEC) res_q <= exec_rsp;
    if (state_q == S_OUT && (!ov_q || out_ready_i)) rsp_q <= res_q;
  end

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= (AW+1)'(HEAP_BYTES)) else $error("heap top past heap");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !job_ready_o) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(rsp_q)) else $error("result dropped");

endmodule

@@ design/segregated_fit_allocator.sv @@
// Top level of the segregated fit allocator: front classifier, queue, back executor.
// Depends on sfa_pkg, sfa_front and sfa_back.
//
//  channel  dir  handshake              payload
//  in       in   in_valid_i/in_ready_o  in_data_i (op, request_size, free_address)
//  out      out  out_valid_o/out_ready_i out_data_o (address, status)
//  cfg      in   cfg_we_i               cfg_data_i (heap_limit_bytes)
//
// Each item passes through these back-end steps in order: the take with its class-head
// read, a header/link read, the execute step with its write back (skipped for a rejected
// word), a link write on an accepted free, and the output load. No new item is taken
// before the output load. After reset the header memory is cleared one granule a cycle,
// and no item is taken until every granule is cleared. The front queue holds two words,
// so up to two input words are still taken while a result waits at the output register.
module segregated_fit_allocator #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sfa_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sfa_pkg::rsp_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [16:0]   cfg_data_i
);

  logic          job_valid, job_ready;
  sfa_pkg::job_t job;
  logic [16:0]   limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 17'h10000;
    else if (cfg_we_i) limit_q <= cfg_data_i;
  end

  sfa_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  sfa_back #(.HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_back (
    .clk_i, .rst_ni, .limit_i(limit_q),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

@@ tb/tb_segregated_fit_allocator.sv @@
// Testbench for segregated_fit_allocator: drives alloc and free words with random idling,
// predicts each response with its own free-list model and checks every word in order.
// Depends on sfa_pkg and the segregated_fit_allocator RTL.
`timescale 1ns / 100ps

module tb_segregated_fit_allocator;

  localparam int HEAP = 65536;
  localparam int HDR = 8;
  localparam int GRAN = HEAP / 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sfa_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sfa_pkg::rsp_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [16:0] cfg_data_i = 17'd65536;

  segregated_fit_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  logic [13:0] head_q [sfa_pkg::NUM_CLASSES];
  logic [12:0] hdr_q [GRAN];
  logic [13:0] link_q [GRAN];
  int unsigned top_q;
  int unsigned limit_q;
  sfa_pkg::rsp_t expected_rsp[$];
  int unsigned live_addr[$];
  int errors = 0;
  bit idle_en = 1'b1;

  function automatic int unsigned round_size(int unsigned s);
    int unsigned st;
    if (s <= 24) return 24;
    if (s <= 128) st = 8;
    else if (s <= 256) st = 16;
    else if (s <= 512) st = 32;
    else if (s <= 1024) st = 64;
    else if (s <= 2048) st = 128;
    else st = 256;
    return (s + st - 1) & ~(st - 1);
  endfunction

  function automatic int unsigned size_to_cls(int unsigned sz);
    int unsigned i;
    if (sz < 16) sz = 16;
    if (sz <= 128) i = (sz >> 3) - 2;
    else if (sz <= 256) i = 14 + ((sz - 128) >> 4);
    else if (sz <= 512) i = 22 + ((sz - 256) >> 5);
    else if (sz <= 1024) i = 30 + ((sz - 512) >> 6);
    else if (sz <= 2048) i = 38 + ((sz - 1024) >> 7);
    else if (sz <= 3840) i = 46 + ((sz - 2048) >> 8);
    else i = sfa_pkg::NUM_CLASSES - 1;
    if (i >= sfa_pkg::NUM_CLASSES) i = sfa_pkg::NUM_CLASSES - 1;
    return i;
  endfunction

  function automatic sfa_pkg::rsp_t predict_heap(sfa_pkg::req_t r);
    sfa_pkg::rsp_t o;
    int unsigned sz, c, g, need, lim, a, st;
    o = '0;
    o.status = sfa_pkg::ST_OK;
    if (r.op == sfa_pkg::OP_ALLOC) begin
      if (r.request_size == 0) o.status = sfa_pkg::ST_ZERO;
      else if (r.request_size > sfa_pkg::MAX_SIZE) o.status = sfa_pkg::ST_OVERSIZE;
      else begin
        sz = round_size(r.request_size);
        c = size_to_cls(sz);
        if (head_q[c] != 0) begin
          g = head_q[c] - 1;
          head_q[c] = link_q[g];
          hdr_q[g] = hdr_q[g] | 13'd1;
          o.address = 16'(g * 8 + HDR);
        end else begin
          need = (HDR + sz + 7) & ~7;
          lim = (limit_q > HEAP) ? HEAP : limit_q;
          if (top_q + need > lim) o.status = sfa_pkg::ST_NO_MEM;
          else begin
            hdr_q[top_q >> 3] = 13'(sz | 1);
            o.address = 16'(top_q + HDR);
            top_q += need;
          end
        end
        if (o.status == sfa_pkg::ST_OK) live_addr.push_back(o.address);
      end
    end else begin
      a = r.free_address;
      if (a < HDR) o.status = sfa_pkg::ST_BAD_ADDR;
      else begin
        st = a - HDR;
        if ((st & 7) != 0 || st >= top_q) o.status = sfa_pkg::ST_BAD_ADDR;
        else begin
          g = st >> 3;
          if (hdr_q[g][0] == 1'b0) o.status = sfa_pkg::ST_NOT_ALLOC;
          else begin
            hdr_q[g] = hdr_q[g] & 13'h1FFE;
            c = size_to_cls(hdr_q[g]);
            link_q[g] = head_q[c];
            head_q[c] = 14'(g + 1);
          end
        end
      end
    end
    return o;
  endfunction

  task automatic send_word(bit op, int unsigned sz, int unsigned fa);
    sfa_pkg::req_t r;
    r.op = op;
    r.request_size = 16'(sz);
    r.free_address = 16'(fa);
    while (idle_en && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_rsp.push_back(predict_heap(r));
  endtask

  always @(posedge clk_i) begin
    sfa_pkg::rsp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data_o);
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (out_data_o.address !== e.address || out_data_o.status !== e.status) begin
          $display("%0t: expected addr %h status %0d, got addr %h status %0d", $time,
                   e.address, e.status, out_data_o.address, out_data_o.status);
          errors++;
        end
      end
    end
    out_ready_i <= !idle_en || ($urandom_range(99) >= 27);
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= 17'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_q = v & 17'h1FFFF;
  endtask

  task automatic free_random_live();
    int unsigned k;
    if (live_addr.size() == 0) return;
    k = $urandom_range(live_addr.size() - 1);
    send_word(sfa_pkg::OP_FREE, $urandom, live_addr[k]);
    live_addr.delete(k);
  endtask

  task automatic test_directed();
    send_word(sfa_pkg::OP_ALLOC, 0, 16'hFFFF);
    send_word(sfa_pkg::OP_ALLOC, 3841, 0);
    send_word(sfa_pkg::OP_ALLOC, 16'hFFFF, 0);
    send_word(sfa_pkg::OP_FREE, 0, 0);
    send_word(sfa_pkg::OP_FREE, 0, 8);
    send_word(sfa_pkg::OP_ALLOC, 1, 0);
    send_word(sfa_pkg::OP_ALLOC, 24, 0);
    send_word(sfa_pkg::OP_ALLOC, 25, 0);
    send_word(sfa_pkg::OP_ALLOC, 3840, 0);
    send_word(sfa_pkg::OP_ALLOC, 129, 0);
    send_word(sfa_pkg::OP_FREE, 0, 8);
    send_word(sfa_pkg::OP_FREE, 0, 8);
    send_word(sfa_pkg::OP_FREE, 0, 12);
    send_word(sfa_pkg::OP_FREE, 0, 16);
    send_word(sfa_pkg::OP_FREE, 0, 16'hFFFF);
    send_word(sfa_pkg::OP_ALLOC, 20, 16'hFFFF);
    send_word(sfa_pkg::OP_ALLOC, 2049, 0);
    live_addr.delete();
    for (int i = 0; i < 3; i++) free_random_live();
  endtask

  task automatic test_exhaust();
    write_limit(4096);
    for (int i = 0; i < 4; i++) send_word(sfa_pkg::OP_ALLOC, 3840, 0);
    write_limit(17'h1FFFF);
    for (int i = 0; i < 12; i++)
      send_word(sfa_pkg::OP_ALLOC, $urandom_range(2049, 3840), 0);
  endtask

  task automatic test_random(int n);
    int unsigned p;
    for (int i = 0; i < n; i++) begin
      idle_en = !(i >= n / 3 && i < n / 3 + 150);
      p = $urandom_range(99);
      if (p < 45) send_word(sfa_pkg::OP_ALLOC, ($urandom_range(9) == 0) ?
                             $urandom_range(3840) : $urandom_range(1, 300), $urandom);
      else if (p < 85) free_random_live();
      else if (p < 92) send_word(sfa_pkg::OP_FREE, $urandom, $urandom_range(top_q + 16));
      else if (p < 96) send_word(sfa_pkg::OP_FREE, $urandom, $urandom);
      else send_word(sfa_pkg::OP_ALLOC, $urandom, $urandom);
      if (i % 450 == 449) write_limit($urandom_range(top_q, 65536));
    end
    idle_en = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < sfa_pkg::NUM_CLASSES; i++) head_q[i] = '0;
    for (int i = 0; i < GRAN; i++) begin
      hdr_q[i] = '0;
      link_q[i] = '0;
    end
    top_q = 0;
    limit_q = 65536;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_exhaust();
    write_limit(65536);
    test_random(1800);
    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
design/sfa_pkg.sv
design/sfa_front.sv
design/sfa_back.sv
design/segregated_fit_allocator.sv
tb/tb_segregated_fit_allocator.sv
